### src/kld_pkg.sv
// shared types and constants for the keyed lz77 block decompressor
package kld_pkg;

	localparam int OUT_LANES = 8;
	localparam int HIST_AW = 16;
	localparam int WINDOW_BYTES = 1 << HIST_AW;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

	localparam logic [31:0] LCG_MUL = 32'd2891336453;
	localparam logic [31:0] LCG_ADD = 32'd3787658861;
	localparam logic [1:0] KEY_ADDR = 2'd0;
	localparam logic [7:0] EXT_MORE = 8'hff;
	localparam logic [3:0] NIB_MAX = 4'hf;
	localparam logic [7:0] MATCH_MIN = 8'd4;

	typedef enum logic [2:0] {
		PH_TOKEN,
		PH_LIT_EXT,
		PH_LITERALS,
		PH_OFF_LO,
		PH_OFF_HI,
		PH_MATCH_EXT
	} phase_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DEC
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RD,
		B_WR,
		B_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_LIT,
		CMD_COPY,
		CMD_ERR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] data;
		logic [HIST_AW-1:0] offs;
		logic blk_end;
	} cmd_t;

endpackage

### src/kld_front.sv
// front end: keystream descramble and sequence parser, one command per item
module kld_front import kld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] in_byte,
	input logic block_end,
	input logic [31:0] key,
	input logic q_full,
	output logic q_push,
	output cmd_t q_cmd
);

	front_state_t state_q, state_nx;
	logic [7:0] byte_q;
	logic end_q;
	logic [31:0] ks_q, ksn_q;
	logic fresh_q, err_q;
	phase_t phase_q, phase_nx;
	logic [31:0] lit_q, lit_nx;
	logic [3:0] nib_q, nib_nx;
	logic [7:0] dlo_q, dlo_nx;
	logic [7:0] dhi_q, dhi_nx;
	logic [HIST_AW:0] prod_q, prod_nx;
	logic err_nx;
	logic [7:0] by;
	logic [HIST_AW-1:0] dist_full;
	logic [32:0] lit_sum;
	logic [7:0] copy_n;
	logic [HIST_AW+1:0] prod_sum;
	logic bad;
	logic take;

	assign take = push && !full;
	assign by = byte_q ^ ksn_q[31:24];
	assign dist_full = {by, dlo_q};
	assign lit_sum = {1'b0, lit_q} + {25'd0, by};
	assign prod_sum = {1'b0, prod_q} + {{(HIST_AW - 6){1'b0}}, copy_n};

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			F_IDLE: if (push) state_nx = F_MUL;
			F_MUL: state_nx = F_DEC;
			F_DEC: if (!q_full) state_nx = F_IDLE;
			default: state_nx = F_IDLE;
		endcase
	end

	always_comb begin
		full = (state_q != F_IDLE);
		q_push = (state_q == F_DEC) && !q_full;
	end

	always_comb begin
		phase_nx = phase_q;
		lit_nx = lit_q;
		nib_nx = nib_q;
		dlo_nx = dlo_q;
		dhi_nx = dhi_q;
		err_nx = err_q;
		copy_n = 8'd0;
		bad = 1'b0;
		q_cmd.kind = CMD_NONE;
		q_cmd.data = by;
		q_cmd.offs = dist_full;
		q_cmd.blk_end = end_q;
		if (err_q) begin
			q_cmd.kind = end_q ? CMD_ERR : CMD_NONE;
		end else begin
			unique case (phase_q)
				PH_TOKEN: begin
					nib_nx = by[3:0];
					lit_nx = {28'd0, by[7:4]};
					if (by[7:4] == NIB_MAX) phase_nx = PH_LIT_EXT;
					else if (by[7:4] != 4'd0) phase_nx = PH_LITERALS;
					else phase_nx = PH_OFF_LO;
				end
				PH_LIT_EXT: begin
					lit_nx = lit_sum[32] ? '1 : lit_sum[31:0];
					if (by != EXT_MORE) phase_nx = (lit_nx != 32'd0) ? PH_LITERALS : PH_OFF_LO;
				end
				PH_LITERALS: begin
					q_cmd.kind = CMD_LIT;
					copy_n = 8'd1;
					if (lit_q != 32'd0) lit_nx = lit_q - 32'd1;
					if (lit_nx == 32'd0) phase_nx = PH_OFF_LO;
				end
				PH_OFF_LO: begin
					dlo_nx = by;
					phase_nx = PH_OFF_HI;
				end
				PH_OFF_HI: begin
					if (dist_full == '0 || {1'b0, dist_full} > prod_q) begin
						bad = 1'b1;
						q_cmd.kind = CMD_ERR;
					end else begin
						q_cmd.kind = CMD_COPY;
						dhi_nx = by;
						copy_n = {4'd0, nib_q} + MATCH_MIN;
						q_cmd.data = copy_n;
						phase_nx = (nib_q == NIB_MAX) ? PH_MATCH_EXT : PH_TOKEN;
					end
				end
				PH_MATCH_EXT: begin
					q_cmd.kind = CMD_COPY;
					q_cmd.offs = {dhi_q, dlo_q};
					copy_n = by;
					if (by != EXT_MORE) phase_nx = PH_TOKEN;
				end
				default: phase_nx = PH_TOKEN;
			endcase
			if (bad && !end_q) err_nx = 1'b1;
		end
		prod_nx = (prod_sum > WINDOW_BYTES[HIST_AW+1:0]) ? WINDOW_BYTES[HIST_AW:0]
			: prod_sum[HIST_AW:0];
		if (end_q) begin
			phase_nx = PH_TOKEN;
			lit_nx = 32'd0;
			nib_nx = 4'd0;
			dlo_nx = 8'd0;
			dhi_nx = 8'd0;
			prod_nx = '0;
			err_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ks_q <= 32'd0;
			fresh_q <= 1'b1;
			err_q <= 1'b0;
			phase_q <= PH_TOKEN;
			lit_q <= 32'd0;
			nib_q <= 4'd0;
			dlo_q <= 8'd0;
			dhi_q <= 8'd0;
			prod_q <= '0;
		end else begin
			state_q <= state_nx;
			if (q_push) begin
				phase_q <= phase_nx;
				lit_q <= lit_nx;
				nib_q <= nib_nx;
				dlo_q <= dlo_nx;
				dhi_q <= dhi_nx;
				prod_q <= prod_nx;
				err_q <= err_nx;
				if (!err_q) ks_q <= ksn_q;
				if (end_q) fresh_q <= 1'b1;
				else if (!err_q) fresh_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= in_byte;
			end_q <= block_end;
		end
		if (state_q == F_MUL) ksn_q <= (fresh_q ? key : ks_q) * LCG_MUL + LCG_ADD;
	end

endmodule

### src/kld_cmdq.sv
// short command queue between parser and copy engine
module kld_cmdq import kld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input cmd_t wr_cmd,
	output logic q_full,
	input logic rd_en,
	output logic q_valid,
	output cmd_t rd_cmd
);

	cmd_t mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wp_q, rp_q;
	logic [CMDQ_AW:0] cnt_q;

	assign q_full = (cnt_q == CMDQ_DEPTH[CMDQ_AW:0]);
	assign q_valid = (cnt_q != '0);
	assign rd_cmd = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_cmd;
	end

endmodule

### src/kld_back.sv
// back end: history memory, match copy and result grouping
module kld_back import kld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input cmd_t q_cmd,
	output logic q_pop,
	input logic pop,
	output logic empty,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic [7:0] out_byte4,
	output logic [7:0] out_byte5,
	output logic [7:0] out_byte6,
	output logic [7:0] out_byte7,
	output logic [3:0] byte_count,
	output logic run_last,
	output logic block_done,
	output logic status
);

	logic [7:0] hist_q [WINDOW_BYTES];
	back_state_t state_q, state_nx;
	logic [HIST_AW-1:0] wp_q, dist_q;
	logic [7:0] rem_q, rdata_q;
	logic end_q, stat_q;
	logic [7:0] lanes_q [OUT_LANES];
	logic [3:0] cnt_q;
	logic ov_q;
	logic [7:0] ob_q [OUT_LANES];
	logic emit_ok;
	logic lit_take, copy_take;
	logic hw_en;
	logic [7:0] hw_data;

	assign emit_ok = !ov_q || pop;
	assign lit_take = q_pop && q_cmd.kind == CMD_LIT;
	assign copy_take = q_pop && q_cmd.kind == CMD_COPY && q_cmd.data != 8'd0;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					case (q_cmd.kind)
						CMD_LIT, CMD_ERR: state_nx = B_EMIT;
						CMD_COPY: state_nx = (q_cmd.data != 8'd0) ? B_RD
							: (q_cmd.blk_end ? B_EMIT : B_IDLE);
						default: state_nx = q_cmd.blk_end ? B_EMIT : B_IDLE;
					endcase
				end
			end
			B_RD: state_nx = B_WR;
			B_WR: state_nx = (rem_q == 8'd1 || cnt_q == 4'(OUT_LANES - 1)) ? B_EMIT : B_RD;
			B_EMIT: if (emit_ok) state_nx = (rem_q == 8'd0) ? B_IDLE : B_RD;
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == B_IDLE) && q_valid;
		hw_en = lit_take || (state_q == B_WR);
		hw_data = (state_q == B_WR) ? rdata_q : q_cmd.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			wp_q <= '0;
			rem_q <= 8'd0;
			cnt_q <= 4'd0;
			ov_q <= 1'b0;
			end_q <= 1'b0;
			stat_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == B_EMIT && emit_ok) ov_q <= 1'b1;
			else if (ov_q && pop) ov_q <= 1'b0;
			if (q_pop) begin
				end_q <= q_cmd.blk_end;
				stat_q <= (q_cmd.kind == CMD_ERR);
				cnt_q <= lit_take ? 4'd1 : 4'd0;
				rem_q <= copy_take ? q_cmd.data : 8'd0;
			end
			if (hw_en) wp_q <= wp_q + 1'b1;
			if (state_q == B_WR) begin
				cnt_q <= cnt_q + 4'd1;
				rem_q <= rem_q - 8'd1;
			end
			if (state_q == B_EMIT && emit_ok) begin
				cnt_q <= 4'd0;
				if (rem_q == 8'd0 && end_q) wp_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) dist_q <= q_cmd.offs;
		if (lit_take) lanes_q[0] <= q_cmd.data;
		if (state_q == B_WR) lanes_q[cnt_q[2:0]] <= rdata_q;
		if (state_q == B_RD) rdata_q <= hist_q[wp_q - dist_q];
		if (hw_en) hist_q[wp_q] <= hw_data;
		if (state_q == B_EMIT && emit_ok) begin
			for (int j = 0; j < OUT_LANES; j++) begin
				ob_q[j] <= (4'(j) < cnt_q) ? lanes_q[j] : 8'd0;
			end
			byte_count <= cnt_q;
			run_last <= (rem_q == 8'd0);
			block_done <= (rem_q == 8'd0) && end_q;
			status <= stat_q;
		end
	end

	assign empty = !ov_q;
	assign out_byte0 = ob_q[0];
	assign out_byte1 = ob_q[1];
	assign out_byte2 = ob_q[2];
	assign out_byte3 = ob_q[3];
	assign out_byte4 = ob_q[4];
	assign out_byte5 = ob_q[5];
	assign out_byte6 = ob_q[6];
	assign out_byte7 = ob_q[7];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(OUT_LANES)) else $error("lane count overflow");
	a_wr_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_WR |-> rem_q != 8'd0) else $error("copy write with nothing left");
	a_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_RD |=> state_q == B_WR) else $error("read not followed by write");

endmodule

### src/keyed_lz77_block_decompressor.sv
// top level: keyed lz77 block decompressor with apb key register
// Compressed bytes enter one per item through push/full; the front end
// captures each item, runs the keystream multiply and parses it, taking no new
// item until its command is handed on, and hands one command per item to a
// four-entry queue. The back end writes literals into the history as it takes
// them and copies matches from the 64 KiB history one byte at a time
// (registered memory read, then write), emitting groups of up to eight bytes.
// Results leave through an output register read with empty/pop.
module keyed_lz77_block_decompressor import kld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic push,
	output logic full,
	input logic [7:0] in_byte,
	input logic block_end,
	input logic pop,
	output logic empty,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic [7:0] out_byte4,
	output logic [7:0] out_byte5,
	output logic [7:0] out_byte6,
	output logic [7:0] out_byte7,
	output logic [3:0] byte_count,
	output logic run_last,
	output logic block_done,
	output logic status
);

	logic [31:0] key_q;
	logic q_full, q_push, q_valid, q_pop;
	cmd_t f_cmd, b_cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == KEY_ADDR) ? key_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= 32'd0;
		end else if (psel && penable && pwrite && paddr == KEY_ADDR) begin
			key_q <= pwdata;
		end
	end

	kld_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.in_byte(in_byte), .block_end(block_end), .key(key_q),
		.q_full(q_full), .q_push(q_push), .q_cmd(f_cmd)
	);

	kld_cmdq u_cmdq (
		.clk(clk), .arst_n(arst_n), .wr_en(q_push), .wr_cmd(f_cmd),
		.q_full(q_full), .rd_en(q_pop), .q_valid(q_valid), .rd_cmd(b_cmd)
	);

	kld_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(b_cmd),
		.q_pop(q_pop), .pop(pop), .empty(empty),
		.out_byte0(out_byte0), .out_byte1(out_byte1), .out_byte2(out_byte2),
		.out_byte3(out_byte3), .out_byte4(out_byte4), .out_byte5(out_byte5),
		.out_byte6(out_byte6), .out_byte7(out_byte7), .byte_count(byte_count),
		.run_last(run_last), .block_done(block_done), .status(status)
	);

endmodule

### tb/sv/kld_checker.sv
// checker: decodes accepted input items and compares the result items
`timescale 1ns / 1ps
module kld_checker import kld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	input logic push,
	input logic full,
	input logic [7:0] in_byte,
	input logic block_end,
	input logic pop,
	input logic empty,
	input logic [63:0] out_lanes,
	input logic [3:0] byte_count,
	input logic run_last,
	input logic block_done,
	input logic status,
	output int fails,
	output int pending
);

	typedef struct packed {
		logic [63:0] lanes;
		logic [3:0] cnt;
		logic last;
		logic done;
		logic bad;
	} group_t;

	group_t groups_due[$];
	logic [7:0] decoded[$];
	logic [7:0] hist [0:WINDOW_BYTES-1];
	logic [31:0] key_reg;
	logic [31:0] ks;
	phase_t ph;
	logic [31:0] lit_left;
	logic [3:0] nib;
	logic [15:0] mdist;
	logic [15:0] wp;
	int produced;
	bit err_held;
	bit fresh;
	int nfail;

	task automatic clear_block();
		ph = PH_TOKEN;
		lit_left = '0;
		nib = '0;
		mdist = '0;
		wp = '0;
		produced = 0;
		err_held = 0;
		fresh = 1;
	endtask

	task automatic emit(input logic [7:0] b);
		hist[wp] = b;
		wp = wp + 16'd1;
		if (produced < WINDOW_BYTES)
			produced++;
		decoded.push_back(b);
	endtask

	task automatic copy_back(input int n);
		for (int i = 0; i < n; i++)
			emit(hist[wp - mdist]);
	endtask

	task automatic add_group(input int pos, input int n, input bit last, input bit done,
			input bit bad);
		group_t g;
		g = '0;
		for (int j = 0; j < n; j++)
			g.lanes[8*j +: 8] = decoded[pos + j];
		g.cnt = 4'(n);
		g.last = last;
		g.done = done;
		g.bad = bad;
		groups_due.push_back(g);
	endtask

	task automatic decode_item(input logic [7:0] raw, input logic fin);
		logic [7:0] p;
		bit bad;
		int pos;
		int n;
		decoded = {};
		bad = 0;
		if (err_held) begin
			if (fin) begin
				add_group(0, 0, 1, 1, 1);
				clear_block();
			end
			return;
		end
		if (fresh) begin
			ks = key_reg;
			fresh = 0;
		end
		ks = ks * LCG_MUL + LCG_ADD;
		p = raw ^ ks[31:24];
		case (ph)
			PH_TOKEN: begin
				nib = p[3:0];
				lit_left = {28'd0, p[7:4]};
				if (p[7:4] == NIB_MAX)
					ph = PH_LIT_EXT;
				else
					ph = (p[7:4] != 0) ? PH_LITERALS : PH_OFF_LO;
			end
			PH_LIT_EXT: begin
				lit_left = (lit_left > 32'hffffffff - p) ? 32'hffffffff : lit_left + p;
				if (p != EXT_MORE)
					ph = (lit_left != 0) ? PH_LITERALS : PH_OFF_LO;
			end
			PH_LITERALS: begin
				emit(p);
				if (lit_left != 0)
					lit_left--;
				if (lit_left == 0)
					ph = PH_OFF_LO;
			end
			PH_OFF_LO: begin
				mdist = {8'h00, p};
				ph = PH_OFF_HI;
			end
			PH_OFF_HI: begin
				mdist = {p, mdist[7:0]};
				if (mdist == 0 || mdist > produced)
					bad = 1;
				else begin
					copy_back(nib + 4);
					ph = (nib == NIB_MAX) ? PH_MATCH_EXT : PH_TOKEN;
				end
			end
			PH_MATCH_EXT: begin
				copy_back(int'(p));
				if (p != EXT_MORE)
					ph = PH_TOKEN;
			end
			default: ph = PH_TOKEN;
		endcase
		if (bad) begin
			add_group(0, 0, 1, fin, 1);
			if (fin)
				clear_block();
			else
				err_held = 1;
			return;
		end
		pos = 0;
		while (pos < decoded.size()) begin
			n = decoded.size() - pos;
			if (n > OUT_LANES)
				n = OUT_LANES;
			add_group(pos, n, pos + n >= decoded.size(), fin && pos + n >= decoded.size(), 0);
			pos += n;
		end
		if (decoded.size() == 0 && fin)
			add_group(0, 0, 1, 1, 0);
		if (fin)
			clear_block();
	endtask

	always @(posedge clk or negedge arst_n) begin
		group_t g;
		if (!arst_n) begin
			key_reg = '0;
			ks = '0;
			groups_due = {};
			nfail = 0;
			clear_block();
			fails <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == KEY_ADDR)
				key_reg = pwdata;
			if (push && !full)
				decode_item(in_byte, block_end);
			if (pop && !empty) begin
				if (groups_due.size() == 0) begin
					nfail++;
					$display("%0t: unexpected item cnt=%0d data=%h", $time, byte_count,
						out_lanes);
				end else begin
					g = groups_due.pop_front();
					if (g.lanes !== out_lanes || g.cnt !== byte_count || g.last !== run_last
							|| g.done !== block_done || g.bad !== status) begin
						nfail++;
						$display("%0t: mismatch exp data=%h cnt=%0d last=%b done=%b st=%b",
							$time, g.lanes, g.cnt, g.last, g.done, g.bad);
						$display("%0t:          act data=%h cnt=%0d last=%b done=%b st=%b",
							$time, out_lanes, byte_count, run_last, block_done, status);
					end
				end
			end
			fails <= nfail;
			pending <= groups_due.size();
		end
	end

endmodule

### tb/sv/testbench.sv
// testbench top: stimulus, key writes and verdict for the decompressor
`timescale 1ns / 1ps
module testbench;
	import kld_pkg::*;

	localparam int IDLE_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic push, full, pop, empty;
	logic [7:0] in_byte;
	logic block_end;
	logic [7:0] ob0, ob1, ob2, ob3, ob4, ob5, ob6, ob7;
	logic [3:0] byte_count;
	logic run_last, block_done, status;
	int fails, pending;

	logic [31:0] key_now, ks;
	bit fresh, latched, quiet;
	int produced, n_items, idle_cyc, hold_req, hold_seen, hold_left;

	keyed_lz77_block_decompressor u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .in_byte(in_byte), .block_end(block_end),
		.pop(pop), .empty(empty),
		.out_byte0(ob0), .out_byte1(ob1), .out_byte2(ob2), .out_byte3(ob3),
		.out_byte4(ob4), .out_byte5(ob5), .out_byte6(ob6), .out_byte7(ob7),
		.byte_count(byte_count), .run_last(run_last), .block_done(block_done),
		.status(status)
	);

	kld_checker u_checker (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .push(push), .full(full),
		.in_byte(in_byte), .block_end(block_end), .pop(pop), .empty(empty),
		.out_lanes({ob7, ob6, ob5, ob4, ob3, ob2, ob1, ob0}), .byte_count(byte_count),
		.run_last(run_last), .block_done(block_done), .status(status),
		.fails(fails), .pending(pending)
	);

	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// receiver with random stalls and a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			pop <= 0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			pop <= 0;
			hold_seen <= hold_req;
			hold_left <= 400;
		end else begin
			pop <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || psel)
			idle_cyc <= 0;
		else if (idle_cyc >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else
			idle_cyc <= idle_cyc + 1;
	end

	task automatic push_item(input logic [7:0] b, input logic e);
		if (!quiet)
			while ($urandom_range(99) < 6) begin
				push <= 0;
				@(posedge clk);
			end
		push <= 1;
		in_byte <= b;
		block_end <= e;
		do @(posedge clk); while (full);
		n_items++;
	endtask

	task automatic input_idle();
		push <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		input_idle();
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_key(input logic [31:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= KEY_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		key_now = v;
	endtask

	// obfuscate one plain byte with the keystream (sent as is once latched) and send it
	task automatic send_plain(input logic [7:0] pb, input logic e);
		logic [7:0] c;
		c = pb;
		if (!latched) begin
			if (fresh) begin
				ks = key_now;
				fresh = 0;
			end
			ks = ks * LCG_MUL + LCG_ADD;
			c = pb ^ ks[31:24];
		end
		push_item(c, e);
		if (e) begin
			fresh = 1;
			latched = 0;
			produced = 0;
		end
	endtask

	// one sequence; last ends the block after the literals, bad: 1 bad offset, 2 bad and end
	task automatic send_seq(input int nlit, input int nib, input bit last, input int bad);
		int r;
		int hi;
		int d;
		int ext;
		logic [3:0] ln;
		ln = (nlit >= 15) ? NIB_MAX : nlit[3:0];
		if (last && nlit == 0) begin
			send_plain({ln, nib[3:0]}, 1);
			return;
		end
		send_plain({ln, nib[3:0]}, 0);
		if (nlit >= 15) begin
			r = nlit - 15;
			while (r >= 255) begin
				send_plain(EXT_MORE, 0);
				r -= 255;
			end
			send_plain(r[7:0], 0);
		end
		for (int i = 0; i < nlit; i++) begin
			produced++;
			send_plain(8'($urandom_range(255)), last && i == nlit - 1);
		end
		if (last)
			return;
		if (bad != 0)
			d = $urandom_range(1) ? 0 : produced + 1 + $urandom_range(10);
		else begin
			hi = (produced > 65535) ? 65535 : produced;
			d = ($urandom_range(3) == 0) ? $urandom_range(hi, 1)
				: $urandom_range((hi > 4) ? 4 : hi, 1);
		end
		send_plain(d[7:0], 0);
		send_plain(d[15:8], bad == 2);
		if (bad == 1)
			latched = 1;
		if (bad != 0)
			return;
		produced += nib + 4;
		if (nib == 15)
			do begin
				ext = ($urandom_range(11) == 0) ? 255 : $urandom_range(12);
				send_plain(ext[7:0], 0);
				produced += ext;
			end while (ext == 255);
	endtask

	function automatic int pick_lits();
		if ($urandom_range(9) == 0)
			return 15 + (($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(20));
		return $urandom_range(6);
	endfunction

	task automatic rand_block();
		int kind;
		int nseq;
		int nl;
		kind = $urandom_range(99);
		nseq = $urandom_range(5);
		if (kind < 4) begin
			send_plain(8'($urandom_range(255)), 1);
			return;
		end
		for (int s = 0; s < nseq; s++) begin
			nl = pick_lits();
			if (produced == 0 && nl == 0)
				nl = 1;
			send_seq(nl, $urandom_range(15), 0, 0);
		end
		if (kind < 10) begin
			send_plain({4'd3, 4'($urandom_range(15))}, 0);
			produced++;
			send_plain(8'($urandom_range(255)), 1'($urandom_range(1)));
			if (!fresh) begin
				produced += 2;
				send_plain(8'($urandom_range(255)), 0);
				send_plain(8'($urandom_range(255)), 0);
				send_plain(8'($urandom_range(255)), 1);
			end
		end else if (kind < 18) begin
			send_seq($urandom_range(3), $urandom_range(15), 0, $urandom_range(3) == 0 ? 2 : 1);
			if (latched) begin
				repeat ($urandom_range(3))
					send_plain(8'($urandom_range(255)), 0);
				send_plain(8'($urandom_range(255)), 1);
			end
		end else
			send_seq(pick_lits(), $urandom_range(15), 1, 0);
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		push = 0;
		in_byte = '0;
		block_end = 0;
		key_now = '0;
		ks = '0;
		fresh = 1;
		latched = 0;
		quiet = 0;
		produced = 0;
		n_items = 0;
		hold_req = 0;
		idle_cyc = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_key(32'h0000_0000);

		// overlapping copies, long match extension, extreme literals
		send_plain(8'h12, 0);
		send_plain(8'hff, 0);
		send_plain(8'h01, 0);
		send_plain(8'h00, 0);
		send_plain(8'h0f, 0);
		send_plain(8'h01, 0);
		send_plain(8'h00, 0);
		send_plain(8'hff, 0);
		send_plain(8'h03, 0);
		send_plain(8'h20, 0);
		send_plain(8'h00, 0);
		send_plain(8'haa, 1);
		// empty block
		send_plain(8'h00, 1);
		// bad offset, then discarded bytes
		send_plain(8'h10, 0);
		send_plain(8'h55, 0);
		send_plain(8'h05, 0);
		send_plain(8'h00, 0);
		latched = 1;
		send_plain(8'h77, 0);
		send_plain(8'h88, 1);
		// zero offset on the final byte
		send_plain(8'h10, 0);
		send_plain(8'h11, 0);
		send_plain(8'h00, 0);
		send_plain(8'h00, 1);
		// block cut off inside a literal run
		send_plain(8'h30, 0);
		send_plain(8'h42, 1);
		drain();
		write_key(32'hffff_ffff);

		n_items = 0;
		while (n_items < 430) begin
			quiet = (n_items >= 100 && n_items < 180);
			if (n_items >= 200 && hold_req == 0)
				hold_req = 1;
			if (n_items >= 300 && n_items < 330) begin
				drain();
				n_items = 330;
			end
			rand_block();
			if (n_items >= 120 && key_now == 32'hffff_ffff) begin
				drain();
				write_key($urandom);
			end else if (n_items >= 250 && key_now != 32'h0000_0001) begin
				drain();
				write_key(32'h0000_0001);
			end
		end
		quiet = 0;
		input_idle();
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
